>>> design/mpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpt_pkg;

  localparam int TableEntries = 64;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int CntW         = $clog2(TableEntries + 1);

  localparam int OpW   = 3;
  localparam int InIdxW = 6;
  localparam int AddrW = 32;
  localparam int ValW  = 8;
  localparam int A16W  = 16;
  localparam int RamOffW  = 13;
  localparam int PageW    = 6;
  localparam int PageOffW = 10;

  localparam logic [A16W-1:0] RamBase = 16'hC000;

  // operation codes
  localparam logic [OpW-1:0] OpAdd    = 3'd0;
  localparam logic [OpW-1:0] OpDelete = 3'd1;
  localparam logic [OpW-1:0] OpSetEn  = 3'd2;
  localparam logic [OpW-1:0] OpRead   = 3'd3;
  localparam logic [OpW-1:0] OpApply  = 3'd4;
  localparam logic [OpW-1:0] OpClear  = 3'd5;

  typedef enum logic [1:0] {
    WrAppend,
    WrShift,
    WrSetEn
  } wr_kind_e;

  typedef enum logic [1:0] {
    OutPlain,
    OutRead,
    OutPatch
  } out_kind_e;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [ValW-1:0]  value;
    logic             enable;
  } entry_t;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [InIdxW-1:0] index;
    logic [AddrW-1:0]  address;
    logic [ValW-1:0]   value;
    logic              enable;
  } item_t;

  typedef struct packed {
    logic                status;
    logic                is_patch;
    logic [AddrW-1:0]    entry_address;
    logic [ValW-1:0]     entry_value;
    logic                entry_enable;
    logic [CntW-1:0]     entry_count;
    logic                ram_hit;
    logic [RamOffW-1:0]  ram_offset;
    logic [PageW-1:0]    page;
    logic [PageOffW-1:0] page_offset;
    logic                last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic      cap;
    logic      ptr_clr;
    logic      ptr_inc;
    logic      rd_en;
    logic      rd_next;
    logic      wr_en;
    wr_kind_e  wr_kind;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      cnt_clr;
    logic      pend_ld;
    logic      pend_clr;
    logic      out_ld;
    out_kind_e out_kind;
    logic      out_status;
    logic      out_last;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           idx_ok;
    logic           full;
    logic           out_free;
    logic           ptr_end;
    logic           next_end;
    logic           rd_enable;
    logic           pend_valid;
  } ctrl_sts_t;

endpackage

`default_nettype wire

>>> design/mpt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mpt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mpt_pkg::ctrl_sts_t sts_i,
  output mpt_pkg::ctrl_cmd_t     cmd_o
);
  import mpt_pkg::*;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SExec   = 3'd1;
  localparam logic [2:0] SRdWait = 3'd2;
  localparam logic [2:0] SSetEn  = 3'd3;
  localparam logic [2:0] SDelRd  = 3'd4;
  localparam logic [2:0] SDelWr  = 3'd5;
  localparam logic [2:0] SApRd   = 3'd6;
  localparam logic [2:0] SApChk  = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.wr_kind    = WrAppend;
    cmd_o.out_kind   = OutPlain;
    cmd_o.out_last   = 1'b1;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = SExec;
        end
      end
      SExec: begin
        case (sts_i.op)
          OpAdd: begin
            if (sts_i.out_free) begin
              cmd_o.wr_en      = !sts_i.full;
              cmd_o.cnt_inc    = !sts_i.full;
              cmd_o.out_ld     = 1'b1;
              cmd_o.out_status = sts_i.full;
              state_d          = SIdle;
            end
          end
          OpDelete, OpSetEn, OpRead: begin
            if (!sts_i.idx_ok) begin
              if (sts_i.out_free) begin
                cmd_o.out_ld     = 1'b1;
                cmd_o.out_status = 1'b1;
                state_d          = SIdle;
              end
            end else if (sts_i.op == OpDelete) begin
              state_d = SDelRd;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = (sts_i.op == OpRead) ? SRdWait : SSetEn;
            end
          end
          OpApply: begin
            cmd_o.ptr_clr  = 1'b1;
            cmd_o.pend_clr = 1'b1;
            state_d        = SApRd;
          end
          OpClear: begin
            if (sts_i.out_free) begin
              cmd_o.cnt_clr = 1'b1;
              cmd_o.out_ld  = 1'b1;
              state_d       = SIdle;
            end
          end
          default: begin
            if (sts_i.out_free) begin
              cmd_o.out_ld     = 1'b1;
              cmd_o.out_status = 1'b1;
              state_d          = SIdle;
            end
          end
        endcase
      end
      SRdWait: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_kind = OutRead;
          state_d        = SIdle;
        end
      end
      SSetEn: begin
        // read data of the target entry is held; rewrite it with new enable
        if (sts_i.out_free) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_kind = WrSetEn;
          cmd_o.out_ld  = 1'b1;
          state_d       = SIdle;
        end
      end
      SDelRd: begin
        if (sts_i.next_end) begin
          if (sts_i.out_free) begin
            cmd_o.cnt_dec = 1'b1;
            cmd_o.out_ld  = 1'b1;
            state_d       = SIdle;
          end
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d       = SDelWr;
        end
      end
      SDelWr: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_kind = WrShift;
        cmd_o.ptr_inc = 1'b1;
        state_d       = SDelRd;
      end
      SApRd: begin
        if (sts_i.ptr_end) begin
          if (sts_i.out_free) begin
            cmd_o.out_ld = 1'b1;
            if (sts_i.pend_valid) begin
              cmd_o.out_kind = OutPatch;
              cmd_o.pend_clr = 1'b1;
            end
            state_d = SIdle;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = SApChk;
        end
      end
      SApChk: begin
        // one enabled patch is held back until it is known whether it is the last
        if (!sts_i.rd_enable) begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = SApRd;
        end else if (!sts_i.pend_valid) begin
          cmd_o.pend_ld = 1'b1;
          cmd_o.ptr_inc = 1'b1;
          state_d       = SApRd;
        end else if (sts_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_kind = OutPatch;
          cmd_o.out_last = 1'b0;
          cmd_o.pend_ld  = 1'b1;
          cmd_o.ptr_inc  = 1'b1;
          state_d        = SApRd;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/mpt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mpt_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mpt_pkg::ctrl_cmd_t cmd_i,
  input  wire mpt_pkg::item_t     item_i,
  output mpt_pkg::ctrl_sts_t      sts_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mpt_pkg::result_t        out_o
);
  import mpt_pkg::*;

  entry_t mem_q [TableEntries];
  entry_t rd_q;

  item_t             item_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic [CntW-1:0]   ptr_nx;
  logic              pend_valid_q, pend_valid_d;
  logic [A16W-1:0]   pend_addr_q;
  logic [ValW-1:0]   pend_val_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, res_d;
  logic              out_free;

  logic [IdxW-1:0]   rd_addr, wr_addr;
  entry_t            wr_data;

  assign ptr_nx   = ptr_q + CntW'(1);
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.op         = item_q.operation;
  assign sts_o.idx_ok     = CntW'(item_q.index) < cnt_q;
  assign sts_o.full       = cnt_q >= CntW'(TableEntries);
  assign sts_o.out_free   = out_free;
  assign sts_o.ptr_end    = ptr_q >= cnt_q;
  assign sts_o.next_end   = ptr_nx >= cnt_q;
  assign sts_o.rd_enable  = rd_q.enable;
  assign sts_o.pend_valid = pend_valid_q;

  // table memory: one write and one registered read per cycle
  assign rd_addr = cmd_i.rd_next ? ptr_nx[IdxW-1:0] : ptr_q[IdxW-1:0];

  always_comb begin
    wr_addr = ptr_q[IdxW-1:0];
    wr_data = rd_q;
    case (cmd_i.wr_kind)
      WrAppend: begin
        wr_addr = cnt_q[IdxW-1:0];
        wr_data = '{addr: item_q.address, value: item_q.value, enable: item_q.enable};
      end
      WrShift: begin
        wr_data = rd_q;
      end
      WrSetEn: begin
        wr_data        = rd_q;
        wr_data.enable = item_q.enable;
      end
      default: begin
        wr_data = rd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      item_q <= item_i;
    end
    if (cmd_i.pend_ld) begin
      pend_addr_q <= rd_q.addr[A16W-1:0];
      pend_val_q  <= rd_q.value;
    end
    if (cmd_i.out_ld) begin
      out_q <= res_d;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CntW'(1);
    end

    ptr_d = ptr_q;
    if (cmd_i.cap) begin
      ptr_d = CntW'(item_i.index);
    end else if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_nx;
    end

    pend_valid_d = pend_valid_q;
    if (cmd_i.pend_ld) begin
      pend_valid_d = 1'b1;
    end else if (cmd_i.pend_clr) begin
      pend_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (cmd_i.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // result builder
  always_comb begin
    res_d             = '0;
    res_d.status      = cmd_i.out_status;
    res_d.entry_count = cnt_d;
    res_d.last        = cmd_i.out_last;
    case (cmd_i.out_kind)
      OutPlain: begin
        res_d.last = 1'b1;
      end
      OutRead: begin
        res_d.entry_address = rd_q.addr;
        res_d.entry_value   = rd_q.value;
        res_d.entry_enable  = rd_q.enable;
        res_d.last          = 1'b1;
      end
      OutPatch: begin
        res_d.is_patch      = 1'b1;
        res_d.entry_address = AddrW'(pend_addr_q);
        res_d.entry_value   = pend_val_q;
        res_d.entry_enable  = 1'b1;
        res_d.ram_hit       = pend_addr_q >= RamBase;
        res_d.ram_offset    = pend_addr_q[RamOffW-1:0];
        res_d.page          = pend_addr_q[A16W-1 -: PageW];
        res_d.page_offset   = pend_addr_q[PageOffW-1:0];
      end
      default: begin
        res_d.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      ptr_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      ptr_q        <= ptr_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

>>> design/memory_patch_table.sv
// Add, clear and undefined codes load their result from the execute state;
// read and set enable pass through one more state after the table read, delete
// shifts each later entry down by a read and a write, and apply reads and checks every stored entry.
// One request is worked at a time; the next is taken the cycle after its
// final result is loaded into the output register, even while that waits.
// Reset clears the entry count and handshake state; table contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module memory_patch_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [2:0]  s_axis_tuser,   // operation
  input  wire logic [47:0] s_axis_tdata,   // index, address, value, enable, pad
  // result side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // status, entry_address, entry_value,
                                           // entry_enable, entry_count, ram_hit,
                                           // ram_offset, page, page_offset, pad
  output logic             m_axis_tuser,   // is_patch
  output logic             m_axis_tlast    // last result of the request
);
  import mpt_pkg::*;

  item_t     item;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  result_t   res;

  // unpack request fields
  assign item.operation = s_axis_tuser;
  assign item.index     = s_axis_tdata[5:0];
  assign item.address   = s_axis_tdata[37:6];
  assign item.value     = s_axis_tdata[45:38];
  assign item.enable    = s_axis_tdata[46];

  // sequencer: decodes the request and steps delete shifts and apply walks
  mpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table memory, count, walk pointer, held patch and output register
  mpt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // pack result fields, highest field first (status is bit 0)
  assign m_axis_tdata = {1'b0,
                         res.page_offset,
                         res.page,
                         res.ram_offset,
                         res.ram_hit,
                         res.entry_count,
                         res.entry_enable,
                         res.entry_value,
                         res.entry_address,
                         res.status};
  assign m_axis_tuser = res.is_patch;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
